FILE: rtl/imhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared sizes, codes and controller/datapath interface types for the
// indexed max-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned SLOT_W   = 6;   // log2(CAPACITY)
  localparam int unsigned CNT_W    = 7;   // holds 0..CAPACITY
  localparam int unsigned KEY_W    = 16;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEL_MAX = 2'd1,
    CMD_CHANGE  = 2'd2,
    CMD_DELETE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DEAD  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TOP,
    S_POS,
    S_LAST,
    S_DN_RD,
    S_DN_RR,
    S_DN_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_WRITE,
    S_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_ALLOC,
    OP_RD_TOP,
    OP_TAKE_TOP,
    OP_TAKE_POS,
    OP_FREE_POS,
    OP_TAKE_LAST,
    OP_RD_LEFT,
    OP_RD_RIGHT,
    OP_DN_STEP,
    OP_RD_PARENT,
    OP_UP_STEP,
    OP_WRITE,
    OP_PUBLISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e err;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic dead;
    logic is_last;
    logic dn_stop;
    logic dn_done;
    logic up_top;
    logic up_done;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/imhq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module imhq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/imhq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_ctrl
// Command sequencer: decodes each item and walks the datapath through the
// lookups, the sift-down and sift-up loops and the final write-back.
// ----------------------------------------------------------------------------
module imhq_ctrl import imhq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_INSERT:  state_d = stat_i.full  ? S_FIN : S_UP_RD;
          CMD_DEL_MAX: state_d = stat_i.empty ? S_FIN : S_TOP;
          default:     state_d = stat_i.dead  ? S_FIN : S_POS;
        endcase
      end
      S_TOP:    state_d = S_LAST;
      S_POS:    state_d = (stat_i.cmd == CMD_CHANGE) ? S_DN_RD : S_LAST;
      S_LAST:   state_d = stat_i.is_last ? S_FIN : S_DN_RD;
      S_DN_RD:  state_d = stat_i.dn_stop ? S_UP_RD : S_DN_RR;
      S_DN_RR:  state_d = S_DN_CMP;
      S_DN_CMP: state_d = stat_i.dn_done ? S_UP_RD : S_DN_RD;
      S_UP_RD:  state_d = stat_i.up_top ? S_WRITE : S_UP_CMP;
      S_UP_CMP: state_d = stat_i.up_done ? S_WRITE : S_UP_RD;
      S_WRITE:  state_d = S_FIN;
      S_FIN: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.err  = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_INSERT: begin
            if (stat_i.full) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_FULL;
            end else begin
              cmd_o.op = OP_ALLOC;
            end
          end
          CMD_DEL_MAX: begin
            if (stat_i.empty) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_EMPTY;
            end else begin
              cmd_o.op = OP_RD_TOP;
            end
          end
          default: begin
            if (stat_i.dead) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ST_DEAD;
            end
          end
        endcase
      end
      S_TOP:    cmd_o.op = OP_TAKE_TOP;
      S_POS:    cmd_o.op = (stat_i.cmd == CMD_CHANGE) ? OP_TAKE_POS : OP_FREE_POS;
      S_LAST:   cmd_o.op = OP_TAKE_LAST;
      S_DN_RD:  cmd_o.op = stat_i.dn_stop ? OP_NONE : OP_RD_LEFT;
      S_DN_RR:  cmd_o.op = OP_RD_RIGHT;
      S_DN_CMP: cmd_o.op = OP_DN_STEP;
      S_UP_RD:  cmd_o.op = stat_i.up_top ? OP_NONE : OP_RD_PARENT;
      S_UP_CMP: cmd_o.op = OP_UP_STEP;
      S_WRITE:  cmd_o.op = OP_WRITE;
      S_FIN:    cmd_o.op = stat_i.out_busy ? OP_NONE : OP_PUBLISH;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/imhq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_dp
// Heap datapath: slot/key/position memories, live flags, fill count, the
// moving entry and the result register.
// ----------------------------------------------------------------------------
module imhq_dp import imhq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic [1:0]        cmd_in_i,
  input  logic [KEY_W-1:0]  key_in_i,
  input  logic [SLOT_W-1:0] handle_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [SLOT_W-1:0] out_handle_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [CNT_W-1:0]  entry_total_o
);

  // latched item
  cmd_e              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [SLOT_W-1:0] hin_q;

  // moving entry (the hole walks, the entry is written once at the end)
  logic [SLOT_W-1:0] cur_h_q, cur_h_d;
  logic [KEY_W-1:0]  cur_k_q, cur_k_d;
  logic [SLOT_W-1:0] cur_slot_q, cur_slot_d;
  logic [SLOT_W-1:0] rm_slot_q, rm_slot_d;
  logic [SLOT_W-1:0] lh_q;
  logic [KEY_W-1:0]  lk_q;

  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [CAPACITY-1:0] live_q, live_d;

  status_e           res_status_q, res_status_d;
  logic [SLOT_W-1:0] res_h_q, res_h_d;
  logic [KEY_W-1:0]  res_k_q, res_k_d;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [SLOT_W-1:0] out_h_q;
  logic [KEY_W-1:0]  out_k_q;
  logic [CNT_W-1:0]  out_total_q;

  // memories
  logic              heap_we;
  logic [SLOT_W-1:0] heap_waddr, heap_raddr;
  logic [SLOT_W-1:0] ord_wdata, ord_rdata;
  logic [KEY_W-1:0]  key_wdata, key_rdata;
  logic              pos_we;
  logic [SLOT_W-1:0] pos_waddr, pos_wdata, pos_rdata;

  imhq_ram #(.Width(SLOT_W), .Depth(CAPACITY)) u_ord_ram (
    .clk_i, .we_i(heap_we), .waddr_i(heap_waddr), .wdata_i(ord_wdata),
    .raddr_i(heap_raddr), .rdata_o(ord_rdata)
  );

  imhq_ram #(.Width(KEY_W), .Depth(CAPACITY)) u_key_ram (
    .clk_i, .we_i(heap_we), .waddr_i(heap_waddr), .wdata_i(key_wdata),
    .raddr_i(heap_raddr), .rdata_o(key_rdata)
  );

  imhq_ram #(.Width(SLOT_W), .Depth(CAPACITY)) u_pos_ram (
    .clk_i, .we_i(pos_we), .waddr_i(pos_waddr), .wdata_i(pos_wdata),
    .raddr_i(hin_q), .rdata_o(pos_rdata)
  );

  // lowest free handle
  logic [SLOT_W-1:0] free_h;
  always_comb begin
    free_h = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!live_q[i]) free_h = SLOT_W'(i);
    end
  end

  // tree addressing
  logic [CNT_W-1:0]  fill_m1;
  logic [SLOT_W-1:0] last_slot;
  logic [CNT_W-1:0]  left_w;
  logic [CNT_W:0]    right_w;
  logic [SLOT_W-1:0] parent;
  logic              right_ok, use_right;
  logic [SLOT_W-1:0] nxt_slot, nxt_h;
  logic [KEY_W-1:0]  nxt_k;
  logic              dn_done, up_done;

  assign fill_m1   = fill_q - CNT_W'(1);
  assign last_slot = fill_m1[SLOT_W-1:0];
  assign left_w    = {cur_slot_q, 1'b1};
  assign right_w   = {1'b0, left_w} + (CNT_W+1)'(1);
  assign parent    = (cur_slot_q - SLOT_W'(1)) >> 1;

  // right child's entry is on the read port during the compare cycle
  assign right_ok  = right_w < {1'b0, fill_q};
  assign use_right = right_ok && (key_rdata > lk_q);
  assign nxt_slot  = use_right ? right_w[SLOT_W-1:0] : left_w[SLOT_W-1:0];
  assign nxt_h     = use_right ? ord_rdata : lh_q;
  assign nxt_k     = use_right ? key_rdata : lk_q;
  assign dn_done   = cur_k_q >= nxt_k;
  assign up_done   = cur_k_q <= key_rdata;

  always_comb begin
    stat_o.cmd      = cmd_q;
    stat_o.full     = fill_q == CNT_W'(CAPACITY);
    stat_o.empty    = fill_q == '0;
    stat_o.dead     = !live_q[hin_q];
    stat_o.is_last  = rm_slot_q == last_slot;
    stat_o.dn_stop  = left_w >= fill_q;
    stat_o.dn_done  = dn_done;
    stat_o.up_top   = cur_slot_q == '0;
    stat_o.up_done  = up_done;
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  always_comb begin
    cur_h_d      = cur_h_q;
    cur_k_d      = cur_k_q;
    cur_slot_d   = cur_slot_q;
    rm_slot_d    = rm_slot_q;
    fill_d       = fill_q;
    live_d       = live_q;
    res_status_d = res_status_q;
    res_h_d      = res_h_q;
    res_k_d      = res_k_q;
    heap_raddr   = '0;
    heap_we      = 1'b0;
    heap_waddr   = cur_slot_q;
    ord_wdata    = cur_h_q;
    key_wdata    = cur_k_q;
    pos_we       = 1'b0;
    pos_waddr    = cur_h_q;
    pos_wdata    = cur_slot_q;
    case (cmd_i.op)
      OP_LOAD: begin
        res_status_d = ST_OK;
        res_h_d      = '0;
        res_k_d      = '0;
      end
      OP_ERR: res_status_d = cmd_i.err;
      OP_ALLOC: begin
        cur_h_d        = free_h;
        cur_k_d        = key_q;
        cur_slot_d     = fill_q[SLOT_W-1:0];
        live_d[free_h] = 1'b1;
        fill_d         = fill_q + CNT_W'(1);
        res_h_d        = free_h;
      end
      OP_RD_TOP: heap_raddr = '0;
      OP_TAKE_TOP: begin
        res_h_d           = ord_rdata;
        res_k_d           = key_rdata;
        live_d[ord_rdata] = 1'b0;
        rm_slot_d         = '0;
        heap_raddr        = last_slot;
      end
      OP_TAKE_POS: begin
        cur_h_d    = hin_q;
        cur_k_d    = key_q;
        cur_slot_d = pos_rdata;
      end
      OP_FREE_POS: begin
        live_d[hin_q] = 1'b0;
        rm_slot_d     = pos_rdata;
        heap_raddr    = last_slot;
      end
      OP_TAKE_LAST: begin
        fill_d     = fill_m1;
        cur_h_d    = ord_rdata;
        cur_k_d    = key_rdata;
        cur_slot_d = rm_slot_q;
      end
      OP_RD_LEFT:  heap_raddr = left_w[SLOT_W-1:0];
      OP_RD_RIGHT: heap_raddr = right_w[SLOT_W-1:0];
      OP_DN_STEP: begin
        if (!dn_done) begin
          // larger child moves up into the hole
          heap_we    = 1'b1;
          ord_wdata  = nxt_h;
          key_wdata  = nxt_k;
          pos_we     = 1'b1;
          pos_waddr  = nxt_h;
          cur_slot_d = nxt_slot;
        end
      end
      OP_RD_PARENT: heap_raddr = parent;
      OP_UP_STEP: begin
        if (!up_done) begin
          // parent moves down into the hole
          heap_we    = 1'b1;
          ord_wdata  = ord_rdata;
          key_wdata  = key_rdata;
          pos_we     = 1'b1;
          pos_waddr  = ord_rdata;
          cur_slot_d = parent;
        end
      end
      OP_WRITE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      live_q <= live_d;
      if (cmd_i.op == OP_PUBLISH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      cmd_q <= cmd_e'(cmd_in_i);
      key_q <= key_in_i;
      hin_q <= handle_in_i;
    end
    if (cmd_i.op == OP_RD_RIGHT) begin
      lh_q <= ord_rdata;
      lk_q <= key_rdata;
    end
    if (cmd_i.op == OP_PUBLISH) begin
      out_status_q <= res_status_q;
      out_h_q      <= res_h_q;
      out_k_q      <= res_k_q;
      out_total_q  <= fill_q;
    end
    cur_h_q      <= cur_h_d;
    cur_k_q      <= cur_k_d;
    cur_slot_q   <= cur_slot_d;
    rm_slot_q    <= rm_slot_d;
    res_status_q <= res_status_d;
    res_h_q      <= res_h_d;
    res_k_q      <= res_k_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_handle_o  = out_h_q;
  assign out_key_o     = out_k_q;
  assign entry_total_o = out_total_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_PUBLISH |-> $countones(live_q) == int'(fill_q))
    else $error("live handles disagree with fill count");

  a_pub_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == OP_PUBLISH))
    else $error("result raised without publish");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_PUBLISH |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten while stalled");

endmodule

FILE: rtl/indexed_max_heap_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_max_heap_queue_top
// Indexed max-priority queue (binary heap, stable handles), 64 entries.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o carry cmd_i, key_i, handle_i. Output
// channel: out_valid_o/out_ready_i carry status_o, out_handle_o, out_key_o,
// entry_total_o. Every item yields exactly one result item.
// One item is worked at a time; in_ready_o is high only while idle.
// Each level walked down or up the heap (at most 6 levels each way) costs
// one read of the single-read-port heap memories (plus one for the second
// child on the way down) before its compare; an error skips the walk.
// Reset empties the queue (all handles free, count zero); the memories
// need no clearing pass. A finished result sits in the output register; a
// new item may be accepted while it waits, and that item's result is held
// back until the receiver has taken the previous one.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue_top import imhq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [SLOT_W-1:0] handle_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [SLOT_W-1:0] out_handle_o,
  output logic [KEY_W-1:0]  out_key_o,
  output logic [CNT_W-1:0]  entry_total_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  imhq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  imhq_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .cmd_in_i      (cmd_i),
    .key_in_i      (key_i),
    .handle_in_i   (handle_i),
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .out_handle_o,
    .out_key_o,
    .entry_total_o
  );

endmodule
